>>> design/tss_pkg.sv
// tss_pkg: shared constants, command codes and config register indices for the TDMA slot scheduler.
// No dependencies.
package tss_pkg;
  localparam int MAX_SLOTS_DEF     = 16;
  localparam int DURATION_BITS_DEF = 28;
  localparam int TIME_W            = 48;
  localparam int CYC_W             = 32;
  localparam int ID_W              = 5;
  localparam int CODE_W            = 3;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;
  localparam logic [1:0] CMD_STOP  = 2'd3;

  localparam logic [1:0] REG_MAC_MODE = 2'd0;
  localparam logic [1:0] REG_OWN_ID   = 2'd1;
  localparam logic [1:0] REG_MIDDLE   = 2'd2;
  localparam logic [1:0] REG_COUNT    = 2'd3;
endpackage

>>> design/tss_ram.sv
// tss_ram: generic single-port synchronous RAM, registered read.
// No dependencies.
module tss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> design/tss_divider.sv
// tss_divider: restoring divider, one quotient bit per cycle; gives the remainder.
// Depends on tss_pkg.
module tss_divider import tss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TIME_W-1:0] dividend,
  input  logic [CYC_W-1:0]  divisor,
  output logic              done,
  output logic [CYC_W-1:0]  remainder
);
  localparam int CNT_W = $clog2(TIME_W + 1);

  logic [TIME_W-1:0] q_r, q_nxt;
  logic [CYC_W:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [CYC_W:0]    trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[CYC_W-1:0], q_r[TIME_W-1]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(TIME_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt = {q_r[TIME_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt  = trial - {1'b0, divisor};
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = busy_r && (cnt_r == CNT_W'(1));
  assign remainder = rem_nxt[CYC_W-1:0];
endmodule

>>> design/tdma_slot_scheduler.sv
// TDMA slot scheduler. The slot table sits in one single-port RAM with a registered read.
// Every input transfer gives one result transfer, and no input is taken while a result
// waits, so a stalled output holds the input off. A tick reads the table entry, then
// gives its result; a write, a stop or an ignored start goes straight to the result. A
// start first makes a pass summing the durations of the N used slots through the RAM
// port, then a 48-step bit-serial division whose remainder aligns the first boundary
// (skipped for a zero cycle length); a mid-cycle start adds a skip pass over past slots.
// The next input can be taken in the cycle after the result transfer.
// Uses tss_pkg, tss_ram, tss_divider.
module tdma_slot_scheduler import tss_pkg::*; #(
  parameter int MAX_SLOTS     = MAX_SLOTS_DEF,
  parameter int DURATION_BITS = DURATION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [4:0]               cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_cmd,
  input  logic [3:0]               in_slot_index,
  input  logic [ID_W-1:0]          in_slot_src,
  input  logic [ID_W-1:0]          in_slot_dest,
  input  logic [CODE_W-1:0]        in_slot_rate,
  input  logic [CODE_W-1:0]        in_slot_kind,
  input  logic [DURATION_BITS-1:0] in_slot_duration_us,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_slot_started,
  output logic                     out_transmit,
  output logic [3:0]               out_slot_number,
  output logic [ID_W-1:0]          out_out_src,
  output logic [ID_W-1:0]          out_out_dest,
  output logic [CODE_W-1:0]        out_out_rate,
  output logic [CODE_W-1:0]        out_out_kind,
  output logic                     out_running,
  output logic                     out_write_rejected
);
  localparam int AW  = $clog2(MAX_SLOTS);
  localparam int CW  = $clog2(MAX_SLOTS + 1);
  localparam int EW  = 2 * ID_W + 2 * CODE_W + DURATION_BITS;
  localparam int SUMW = CYC_W + CW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TRD   = 4'd1;
  localparam logic [3:0] S_TUSE  = 4'd2;
  localparam logic [3:0] S_SRD   = 4'd3;
  localparam logic [3:0] S_SACC  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_DWAIT = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_KRD   = 4'd8;
  localparam logic [3:0] S_KUSE  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] st_r, st_nxt;
  logic mode_r, middle_r;
  logic [ID_W-1:0] own_r;
  logic [4:0] count_r;

  logic [TIME_W-1:0] now_r, now_nxt, nst_r, nst_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic act_r, act_nxt;
  logic [CYC_W-1:0] cyc_r, cyc_nxt;
  logic [SUMW-1:0] sum_r, sum_nxt;
  logic [CW-1:0] k_r, k_nxt;

  logic o_valid_r, o_valid_nxt;
  logic o_st_r, o_st_nxt, o_tx_r, o_tx_nxt, o_rej_r, o_rej_nxt;
  logic [3:0] o_num_r, o_num_nxt;
  logic [ID_W-1:0] o_src_r, o_src_nxt, o_dst_r, o_dst_nxt;
  logic [CODE_W-1:0] o_rate_r, o_rate_nxt, o_kind_r, o_kind_nxt;
  logic [CYC_W-1:0] rmd_r, rmd_nxt;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic [DURATION_BITS-1:0] e_dur;
  logic [ID_W-1:0] e_src, e_dst;
  logic [CODE_W-1:0] e_rate, e_kind;

  logic div_start, div_done;
  logic [CYC_W-1:0] div_rem;

  logic [CW-1:0] used;
  logic in_fire;
  logic [AW-1:0] cur_pos;
  logic [TIME_W-1:0] nst_align;
  logic [TIME_W-1:0] nst_step;

  assign used = (int'(count_r) > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(count_r);
  assign in_ready = (st_r == S_IDLE) && !o_valid_r;
  assign in_fire = in_valid && in_ready;
  assign cur_pos = ({1'b0, cur_r} < (AW+1)'(MAX_SLOTS)) ? cur_r : '0;
  assign {e_src, e_dst, e_rate, e_kind, e_dur} = ram_rdata;
  // next multiple of the cycle length: now - (now mod cycle) + cycle
  assign nst_align = now_r - TIME_W'(rmd_r) + TIME_W'(cyc_r);
  assign nst_step = nst_r + TIME_W'(e_dur);

  tss_ram #(.WIDTH(EW), .DEPTH(MAX_SLOTS)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  tss_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(now_r), .divisor(cyc_r),
    .done(div_done), .remainder(div_rem)
  );

  always_comb begin
    st_nxt = st_r;
    now_nxt = now_r; nst_nxt = nst_r; cur_nxt = cur_r; act_nxt = act_r;
    cyc_nxt = cyc_r; sum_nxt = sum_r; k_nxt = k_r; rmd_nxt = rmd_r;
    o_valid_nxt = o_valid_r && !out_ready;
    o_st_nxt = o_st_r; o_tx_nxt = o_tx_r; o_rej_nxt = o_rej_r; o_num_nxt = o_num_r;
    o_src_nxt = o_src_r; o_dst_nxt = o_dst_r; o_rate_nxt = o_rate_r; o_kind_nxt = o_kind_r;
    ram_we = 1'b0;
    ram_addr = cur_pos;
    ram_wdata = {in_slot_src, in_slot_dest, in_slot_rate, in_slot_kind, in_slot_duration_us};
    div_start = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          o_st_nxt = 1'b0; o_tx_nxt = 1'b0; o_rej_nxt = 1'b0; o_num_nxt = '0;
          o_src_nxt = '0; o_dst_nxt = '0; o_rate_nxt = '0; o_kind_nxt = '0;
          case (in_cmd)
            CMD_TICK: begin
              now_nxt = now_r + 1'b1;
              st_nxt = S_TRD;
            end
            CMD_WRITE: begin
              if (act_r) begin
                o_rej_nxt = 1'b1;
              end else if (int'(in_slot_index) < MAX_SLOTS) begin
                ram_we = 1'b1;
                ram_addr = AW'(in_slot_index);
              end
              st_nxt = S_OUT;
            end
            CMD_START: begin
              if (act_r || used == '0) begin
                st_nxt = S_OUT;
              end else begin
                sum_nxt = '0; k_nxt = '0; cur_nxt = '0;
                st_nxt = S_SRD;
              end
            end
            default: begin
              act_nxt = 1'b0; cur_nxt = '0;
              st_nxt = S_OUT;
            end
          endcase
        end
      end
      S_TRD: st_nxt = S_TUSE;
      S_TUSE: begin
        if (act_r && now_r >= nst_r) begin
          o_st_nxt = 1'b1;
          o_num_nxt = 4'(cur_pos);
          o_src_nxt = e_src; o_dst_nxt = e_dst; o_rate_nxt = e_rate; o_kind_nxt = e_kind;
          o_tx_nxt = mode_r ? (e_src != '0) : (e_src == own_r);
          nst_nxt = nst_step;
          cur_nxt = ((CW'(cur_pos) + 1'b1) >= used) ? '0 : cur_pos + 1'b1;
        end
        st_nxt = S_OUT;
      end
      S_SRD: begin
        ram_addr = AW'(k_r);
        st_nxt = S_SACC;
      end
      S_SACC: begin
        sum_nxt = sum_r + SUMW'(e_dur);
        k_nxt = k_r + 1'b1;
        if (k_r + 1'b1 >= used) begin
          st_nxt = S_DIV;
        end else begin
          st_nxt = S_SRD;
        end
      end
      S_DIV: begin
        cyc_nxt = (sum_r > SUMW'({CYC_W{1'b1}})) ? {CYC_W{1'b1}} : CYC_W'(sum_r);
        act_nxt = 1'b1;
        if (cyc_nxt == '0) begin
          nst_nxt = now_r;
          st_nxt = S_OUT;
        end else begin
          st_nxt = S_DWAIT;
        end
      end
      S_DWAIT: begin
        div_start = (k_r != '0);
        k_nxt = '0;
        if (div_done) begin
          rmd_nxt = div_rem;
          st_nxt = S_MUL;
        end
      end
      S_MUL: begin
        nst_nxt = nst_align;
        if (middle_r && used > CW'(1)) begin
          nst_nxt = nst_align - TIME_W'(cyc_r);
          st_nxt = S_KRD;
        end else begin
          st_nxt = S_OUT;
        end
      end
      S_KRD: begin
        if (k_r < used && nst_r < now_r) begin
          st_nxt = S_KUSE;
        end else begin
          st_nxt = S_OUT;
        end
      end
      S_KUSE: begin
        nst_nxt = nst_step;
        cur_nxt = ((CW'(cur_pos) + 1'b1) >= used) ? '0 : cur_pos + 1'b1;
        k_nxt = k_r + 1'b1;
        st_nxt = S_KRD;
      end
      S_OUT: begin
        o_valid_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      mode_r <= 1'b0; own_r <= ID_W'(1); middle_r <= 1'b0; count_r <= '0;
      now_r <= '0; nst_r <= '0; cur_r <= '0; act_r <= 1'b0; cyc_r <= '0;
      o_valid_r <= 1'b0;
      k_r <= '0;
    end else begin
      st_r <= st_nxt;
      now_r <= now_nxt; nst_r <= nst_nxt; cur_r <= cur_nxt; act_r <= act_nxt;
      cyc_r <= cyc_nxt; o_valid_r <= o_valid_nxt; k_r <= k_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_MAC_MODE: mode_r <= cfg_data[0];
          REG_OWN_ID:   own_r <= cfg_data;
          REG_MIDDLE:   middle_r <= cfg_data[0];
          REG_COUNT:    count_r <= cfg_data;
          default: ;
        endcase
      end
    end
    sum_r <= sum_nxt; rmd_r <= rmd_nxt;
    o_st_r <= o_st_nxt; o_tx_r <= o_tx_nxt; o_rej_r <= o_rej_nxt; o_num_r <= o_num_nxt;
    o_src_r <= o_src_nxt; o_dst_r <= o_dst_nxt; o_rate_r <= o_rate_nxt;
    o_kind_r <= o_kind_nxt;
  end

  assign out_valid = o_valid_r;
  assign out_slot_started = o_st_r;
  assign out_transmit = o_tx_r;
  assign out_slot_number = o_num_r;
  assign out_out_src = o_src_r;
  assign out_out_dest = o_dst_r;
  assign out_out_rate = o_rate_r;
  assign out_out_kind = o_kind_r;
  assign out_running = act_r;
  assign out_write_rejected = o_rej_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (st_r == S_IDLE)) else $error("ready outside idle");
  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_OUT) |=> o_valid_r) else $error("result not presented");
  a_rej_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_rej_r) |-> !o_st_r) else $error("reject with slot start");
  a_cur_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE && !act_r) |-> (cur_r == '0))
    else $error("slot index kept while stopped");
endmodule
